// ===== hw/rtl/bmf_pkg.sv =====
`default_nettype none
package bmf_pkg;

   localparam int XW = 32;
   localparam int WW = 31;
   localparam int SW = 16;
   localparam int HW = 16;
   localparam int IDXW = 8;
   localparam int DATAW = 32;

   localparam int FRACW = 16;
   localparam int LOGW = 22;
   localparam int MANW = 31;

   localparam logic [IDXW-1:0] REG_CENTER = 8'd0;
   localparam logic [IDXW-1:0] REG_WIDTH = 8'd1;
   localparam logic [IDXW-1:0] REG_SLOPE = 8'd2;
   localparam logic [IDXW-1:0] REG_HEIGHT = 8'd3;

   localparam logic [XW-1:0] CENTER_RST = 32'd0;
   localparam logic [WW-1:0] WIDTH_RST = 31'd65536;
   localparam logic [SW-1:0] SLOPE_RST = 16'd256;
   localparam logic [HW-1:0] HEIGHT_RST = 16'd32768;

   typedef struct packed {
      logic inv;
      logic zero;
      logic lneg;
      logic eneg;
      logic big;
   } side_type;

   function automatic logic [31:0] bmf_exp_coef(input int k);
      logic [63:0] c;
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      c = 64'd1 << 31;
      for (int j = 1; j <= k; j++) begin
         v = c << 30;
         r = '0;
         b = 64'd1 << 62;
         for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         c = r;
      end
      return c[31:0];
   endfunction

   function automatic logic [5:0] bmf_msb(input logic [32:0] v);
      logic [5:0] r;
      r = '0;
      for (int i = 0; i < 33; i++) begin
         if (v[i]) begin
            r = 6'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [MANW-1:0] bmf_norm(input logic [32:0] v, input logic [5:0] e);
      logic [63:0] t;
      if (e <= 6'd30) begin
         t = {31'd0, v} << (6'd30 - e);
      end else begin
         t = {31'd0, v} >> (e - 6'd30);
      end
      return t[MANW-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bmf_if.sv =====
`default_nettype none
interface bmf_req_if;
   logic valid;
   logic ready;
   logic [bmf_pkg::XW-1:0] crisp_value;
   logic value_invalid;
   modport source(output valid, output crisp_value, output value_invalid, input ready);
   modport sink(input valid, input crisp_value, input value_invalid, output ready);
endinterface

interface bmf_rsp_if;
   logic valid;
   logic ready;
   logic [bmf_pkg::HW-1:0] membership_degree;
   logic result_invalid;
   modport source(output valid, output membership_degree, output result_invalid, input ready);
   modport sink(input valid, input membership_degree, input result_invalid, output ready);
endinterface

interface bmf_csr_if;
   logic valid;
   logic ready;
   logic [bmf_pkg::IDXW-1:0] index;
   logic [bmf_pkg::DATAW-1:0] data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bell_membership_function_top.sv =====
`default_nettype none
// Throughput: one item per cycle; the whole pipeline holds while a result is not taken.
// The two 16-step log2 lanes, the 16-step exp2 chain and the 16-step divider set the depth.
// Reset is synchronous and active high; it clears all valid bits and loads the
// register defaults (center 0, width 1.0, slope 1.0, height 1.0).
module bell_membership_function_top (
   input wire logic clock,
   input wire logic reset,
   bmf_req_if.sink req_chan,
   bmf_rsp_if.source rsp_chan,
   bmf_csr_if.sink csr_chan
);
   import bmf_pkg::*;

   localparam int NST = 55;
   localparam int S_LOG = 2;
   localparam int S_MUL = 19;
   localparam int S_G = 20;
   localparam int S_DD = 37;
   localparam int S_OUT = 54;

   logic signed [XW-1:0] center_ff;
   logic [WW-1:0] width_ff;
   logic signed [SW-1:0] slope_ff;
   logic [HW-1:0] height_ff;

   logic [NST-1:0] v_ff;
   logic adv;
   side_type sd_ff [0:NST-2];

   logic signed [32:0] d0_ff;
   logic [32:0] a1_ff;
   logic [5:0] e1_ff;
   logic [30:0] w1_ff;
   logic [5:0] ew1_ff;

   logic [MANW-1:0] mn_ff [0:16];
   logic [MANW-1:0] mw_ff [0:16];
   logic [FRACW-1:0] fn_ff [0:16];
   logic [FRACW-1:0] fw_ff [0:16];
   logic [5:0] en_ff [0:16];
   logic [5:0] ew_ff [0:16];

   logic [37:0] prod_ff;
   logic [31:0] p_ff [0:16];
   logic [FRACW-1:0] f_ff [0:16];
   logic [4:0] n_ff [0:16];

   logic [80:0] rem_ff [0:16];
   logic [80:0] dv_ff [0:16];
   logic [HW-1:0] q_ff [0:16];

   logic [HW-1:0] deg_ff;
   logic inv_ff;

   assign adv = !v_ff[S_OUT] || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = v_ff[S_OUT];
   assign rsp_chan.membership_degree = deg_ff;
   assign rsp_chan.result_invalid = inv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= CENTER_RST;
         width_ff <= WIDTH_RST;
         slope_ff <= SLOPE_RST;
         height_ff <= HEIGHT_RST;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_CENTER: center_ff <= csr_chan.data;
            REG_WIDTH: width_ff <= csr_chan.data[WW-1:0];
            REG_SLOPE: slope_ff <= csr_chan.data[SW-1:0];
            REG_HEIGHT: height_ff <= csr_chan.data[HW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NST-2:0], req_chan.valid};
      end
   end

   logic [32:0] a1_in;
   logic [30:0] w1_in;
   logic [SW-1:0] sabs;
   logic signed [22:0] lval;
   logic [21:0] labs;
   logic [39:0] gsum;
   logic [31:0] g;
   logic [63:0] dd;
   side_type sd1_in;
   side_type sdm_in;
   side_type sdg_in;

   always_comb begin
      a1_in = d0_ff[32] ? 33'(-d0_ff) : 33'(d0_ff);
      w1_in = (width_ff == '0) ? 31'd1 : width_ff;
      sabs = slope_ff[SW-1] ? 16'(-slope_ff) : 16'(slope_ff);
      lval = signed'({1'b0, en_ff[16], fn_ff[16]}) - signed'({1'b0, ew_ff[16], fw_ff[16]});
      labs = lval[22] ? 22'(-lval) : 22'(lval);
      gsum = {1'b0, prod_ff, 1'b0} + 40'd128;
      g = gsum[39:8];
      dd = 64'd1073741824 + ({32'd0, p_ff[16]} << n_ff[16]);
      sd1_in = sd_ff[0];
      sd1_in.zero = (a1_in == '0);
      sdm_in = sd_ff[S_MUL-1];
      sdm_in.lneg = lval[22];
      sdg_in = sd_ff[S_MUL];
      sdg_in.big = (g[31:16] >= 16'd32);
      sdg_in.eneg = (g != '0) && (sd_ff[S_MUL].lneg != slope_ff[SW-1]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d0_ff <= 33'(signed'(req_chan.crisp_value)) - 33'(center_ff);
         sd_ff[0] <= '{inv: req_chan.value_invalid, default: 1'b0};

         a1_ff <= a1_in;
         e1_ff <= bmf_msb(a1_in);
         w1_ff <= w1_in;
         ew1_ff <= bmf_msb({2'b00, w1_in});
         sd_ff[1] <= sd1_in;

         mn_ff[0] <= bmf_norm(a1_ff, e1_ff);
         mw_ff[0] <= bmf_norm({2'b00, w1_ff}, ew1_ff);
         en_ff[0] <= e1_ff;
         ew_ff[0] <= ew1_ff;
         fn_ff[0] <= '0;
         fw_ff[0] <= '0;
         sd_ff[S_LOG] <= sd_ff[1];

         prod_ff <= 38'(labs) * 38'(sabs);
         sd_ff[S_MUL] <= sdm_in;

         p_ff[0] <= 32'd1073741824;
         f_ff[0] <= g[FRACW-1:0];
         n_ff[0] <= g[20:16];
         sd_ff[S_G] <= sdg_in;

         rem_ff[0] <= {17'd0, ({48'd0, height_ff} << 31) + dd};
         dv_ff[0] <= {16'd0, dd, 1'b0};
         q_ff[0] <= '0;
         sd_ff[S_DD] <= sd_ff[S_DD-1];
      end
   end

   for (genvar k = 0; k < 16; k++) begin : g_log
      logic [61:0] sqn;
      logic [61:0] sqw;
      logic [31:0] tn;
      logic [31:0] tw;
      assign sqn = 62'(mn_ff[k]) * 62'(mn_ff[k]);
      assign sqw = 62'(mw_ff[k]) * 62'(mw_ff[k]);
      assign tn = sqn[61:30];
      assign tw = sqw[61:30];
      always_ff @(posedge clock) begin
         if (adv) begin
            mn_ff[k+1] <= tn[31] ? tn[31:1] : tn[30:0];
            mw_ff[k+1] <= tw[31] ? tw[31:1] : tw[30:0];
            fn_ff[k+1] <= {fn_ff[k][FRACW-2:0], tn[31]};
            fw_ff[k+1] <= {fw_ff[k][FRACW-2:0], tw[31]};
            en_ff[k+1] <= en_ff[k];
            ew_ff[k+1] <= ew_ff[k];
            sd_ff[S_LOG+k+1] <= sd_ff[S_LOG+k];
         end
      end
   end

   for (genvar k = 1; k <= 16; k++) begin : g_exp
      localparam logic [31:0] COEF = bmf_exp_coef(k);
      logic [63:0] pm;
      logic [63:0] pr;
      assign pm = {32'd0, p_ff[k-1]} * {32'd0, COEF};
      assign pr = (pm + 64'd536870912) >> 30;
      always_ff @(posedge clock) begin
         if (adv) begin
            p_ff[k] <= f_ff[k-1][16-k] ? pr[31:0] : p_ff[k-1];
            f_ff[k] <= f_ff[k-1];
            n_ff[k] <= n_ff[k-1];
            sd_ff[S_G+k] <= sd_ff[S_G+k-1];
         end
      end
   end

   for (genvar j = 0; j < 16; j++) begin : g_div
      logic [80:0] ds;
      logic take;
      assign ds = dv_ff[j] << (15 - j);
      assign take = rem_ff[j] >= ds;
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j+1] <= take ? rem_ff[j] - ds : rem_ff[j];
            dv_ff[j+1] <= dv_ff[j];
            q_ff[j+1] <= q_ff[j] | (HW'(take) << (15 - j));
            sd_ff[S_DD+j+1] <= sd_ff[S_DD+j];
         end
      end
   end

   side_type sl;
   logic [HW:0] half;
   logic [HW-1:0] qv;
   logic [HW-1:0] deg_in;

   always_comb begin
      sl = sd_ff[S_OUT-1];
      half = ({1'b0, height_ff} + 17'd1) >> 1;
      qv = sl.big ? '0 : q_ff[16];
      priority if (sl.inv) begin
         deg_in = '0;
      end else if (sl.zero) begin
         if (slope_ff > 0) begin
            deg_in = height_ff;
         end else if (slope_ff == 0) begin
            deg_in = half[HW-1:0];
         end else begin
            deg_in = '0;
         end
      end else if (sl.eneg) begin
         deg_in = height_ff - qv;
      end else begin
         deg_in = qv;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         deg_ff <= deg_in;
         inv_ff <= sl.inv;
      end
   end

`ifndef SYNTH
   a_inv_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.result_invalid |-> rsp_chan.membership_degree == '0)
      else $error("invalid result with nonzero degree");
   a_le_height: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.membership_degree <= height_ff)
      else $error("degree above height");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("input taken during output stall");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v_ff))
      else $error("pipeline moved while stalled");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_bell_membership_function_top.sv =====
`timescale 1ns / 1ps
module tb_bell_membership_function_top;
   import bmf_pkg::*;

   typedef struct packed {
      logic [XW-1:0] crisp_value;
      logic value_invalid;
   } input_item_type;

   typedef struct packed {
      logic [HW-1:0] membership_degree;
      logic result_invalid;
   } result_item_type;

   localparam int LATENCY = 55;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bmf_req_if req_chan();
   bmf_rsp_if rsp_chan();
   bmf_csr_if csr_chan();

   bell_membership_function_top dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source),
      .csr_chan(csr_chan.sink)
   );

   logic signed [XW-1:0] bell_center;
   logic [WW-1:0] bell_width;
   logic signed [SW-1:0] bell_slope;
   logic [HW-1:0] bell_height;

   input_item_type pending_inputs[$];
   result_item_type expected_degrees[$];
   int error_count = 0;
   int cycle_count = 0;
   int checked_count = 0;
   int invalid_seen = 0;
   bit quiet_phase = 1'b0;
   bit req_taken = 1'b0;
   int send_gap = 0;
   int take_gap = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] log2_fixed(input logic [63:0] v);
      int e;
      logic [63:0] m;
      logic [63:0] fr;
      e = 63;
      fr = '0;
      while (e > 0 && v[e] == 1'b0) e--;
      if (e <= 30) m = v << (30 - e);
      else m = v >> (e - 30);
      for (int k = 0; k < 16; k++) begin
         m = (m * m) >> 30;
         fr = fr << 1;
         if (m >= (64'd1 << 31)) begin
            fr[0] = 1'b1;
            m = m >> 1;
         end
      end
      return (64'(e) << 16) | fr;
   endfunction

   function automatic logic [63:0] exp2_fraction(input logic [15:0] f);
      logic [63:0] c;
      logic [63:0] p;
      c = 64'd1 << 31;
      p = 64'd1 << 30;
      for (int k = 1; k <= 16; k++) begin
         c = int_sqrt(c << 30);
         if (f[16 - k]) p = (p * c + (64'd1 << 29)) >> 30;
      end
      return p;
   endfunction

   function automatic result_item_type predict_degree(input input_item_type it);
      result_item_type r;
      logic signed [63:0] delta;
      logic signed [63:0] lval;
      logic [63:0] a;
      logic [63:0] w;
      logic [63:0] h;
      logic [63:0] q;
      logic [63:0] g;
      logic [63:0] n;
      logic [63:0] labs;
      logic [63:0] sabs;
      logic [63:0] dd;
      logic [63:0] res;
      bit eneg;
      r.result_invalid = 1'b0;
      if (it.value_invalid) begin
         r.membership_degree = '0;
         r.result_invalid = 1'b1;
         return r;
      end
      h = 64'(bell_height);
      delta = 64'(signed'(it.crisp_value)) - 64'(bell_center);
      a = delta < 0 ? 64'(-delta) : 64'(delta);
      if (a == 0) begin
         if (bell_slope > 0) res = h;
         else if (bell_slope == 0) res = (h + 1) >> 1;
         else res = 0;
      end else begin
         w = bell_width != 0 ? 64'(bell_width) : 64'd1;
         lval = signed'(log2_fixed(a)) - signed'(log2_fixed(w));
         labs = lval < 0 ? 64'(-lval) : 64'(lval);
         sabs = bell_slope < 0 ? 64'(-64'(bell_slope)) : 64'(bell_slope);
         g = (2 * labs * sabs + 128) >> 8;
         eneg = g != 0 && ((lval < 0) != (bell_slope < 0));
         n = g >> 16;
         if (n >= 32) begin
            q = 0;
         end else begin
            dd = (64'd1 << 30) + (exp2_fraction(g[15:0]) << n);
            q = ((h << 31) + dd) / (2 * dd);
         end
         res = eneg ? h - q : q;
      end
      r.membership_degree = res[15:0];
      return r;
   endfunction

   task automatic write_register(input logic [IDXW-1:0] idx, input logic [DATAW-1:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      case (idx)
         REG_CENTER: bell_center = value;
         REG_WIDTH: bell_width = value[WW-1:0];
         REG_SLOPE: bell_slope = value[SW-1:0];
         REG_HEIGHT: bell_height = value[HW-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic drain_results();
      while (pending_inputs.size() != 0 || expected_degrees.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic queue_input(input logic [XW-1:0] x, input logic inv);
      input_item_type it;
      it.crisp_value = x;
      it.value_invalid = inv;
      pending_inputs.push_back(it);
   endtask

   function automatic logic [XW-1:0] random_crisp();
      int unsigned sel;
      logic [XW-1:0] off;
      sel = $urandom_range(0, 9);
      case (sel)
         0: return $urandom();
         1: return bell_center;
         2, 3: off = $urandom_range(0, 1 << 20);
         4: off = $urandom_range(0, 255);
         default: off = 32'(bell_width) * $urandom_range(0, 4) + $urandom_range(0, 1 << 16);
      endcase
      return $urandom_range(0, 1) ? bell_center + off : bell_center - off;
   endfunction

   task automatic random_settings();
      case ($urandom_range(0, 3))
         0: write_register(REG_CENTER, $urandom());
         1: write_register(REG_CENTER, $urandom_range(0, 1 << 22) - (1 << 21));
         default: write_register(REG_CENTER, 32'd0);
      endcase
      case ($urandom_range(0, 3))
         0: write_register(REG_WIDTH, $urandom() & 32'h7fffffff);
         1: write_register(REG_WIDTH, $urandom_range(0, 1 << 10));
         default: write_register(REG_WIDTH, $urandom_range(1 << 14, 1 << 20));
      endcase
      case ($urandom_range(0, 3))
         0: write_register(REG_SLOPE, $urandom_range(0, 65535));
         1: write_register(REG_SLOPE, 32'($signed(16'($urandom_range(0, 2048) - 1024))));
         default: write_register(REG_SLOPE, $urandom_range(1, 1024));
      endcase
      write_register(REG_HEIGHT, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                            : $urandom_range(0, 32768));
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap <= 0;
      end else if (req_chan.valid && !req_taken) begin
      end else if (send_gap > 0) begin
         req_chan.valid <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (pending_inputs.size() != 0) begin
         req_chan.valid <= 1'b1;
         req_chan.crisp_value <= pending_inputs[0].crisp_value;
         req_chan.value_invalid <= pending_inputs[0].value_invalid;
         if (!quiet_phase && $urandom_range(0, 15) == 0) send_gap <= $urandom_range(1, 18);
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         take_gap <= 0;
      end else if (take_gap > 0) begin
         rsp_chan.ready <= 1'b0;
         take_gap <= take_gap - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (!quiet_phase && $urandom_range(0, 15) == 0) take_gap <= $urandom_range(1, 18);
      end
   end

   always @(posedge clock) begin
      result_item_type want;
      req_taken = req_chan.valid && req_chan.ready && !reset;
      if (!reset) begin
         cycle_count++;
         if (req_chan.valid && req_chan.ready && pending_inputs.size() != 0) begin
            expected_degrees.push_back(predict_degree(pending_inputs.pop_front()));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_degrees.size() == 0) begin
               report_mismatch("transfer with nothing expected", rsp_chan.membership_degree, 0);
            end else begin
               want = expected_degrees.pop_front();
               checked_count++;
               if (want.result_invalid) invalid_seen++;
               if (rsp_chan.membership_degree !== want.membership_degree)
                  report_mismatch("membership_degree", rsp_chan.membership_degree,
                                  want.membership_degree);
               if (rsp_chan.result_invalid !== want.result_invalid)
                  report_mismatch("result_invalid", rsp_chan.result_invalid,
                                  want.result_invalid);
            end
         end
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_bell_membership_function_top failed");
            $finish;
         end
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.crisp_value = '0;
      req_chan.value_invalid = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;
      bell_center = CENTER_RST;
      bell_width = WIDTH_RST;
      bell_slope = SLOPE_RST;
      bell_height = HEIGHT_RST;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: center, both signs around it, the field extremes and invalid inputs.
      queue_input(32'd0, 1'b0);
      queue_input(32'd65536, 1'b0);
      queue_input(-32'sd65536, 1'b0);
      queue_input(32'h7fffffff, 1'b0);
      queue_input(32'h80000000, 1'b0);
      queue_input(32'd1, 1'b0);
      queue_input(32'hffffffff, 1'b1);
      queue_input(32'd0, 1'b1);
      drain_results();

      // Zero width, zero slope, extreme negative and positive slopes, at and off the center.
      write_register(REG_WIDTH, 32'd0);
      write_register(REG_SLOPE, 32'd0);
      queue_input(32'd0, 1'b0);
      queue_input(32'd12345, 1'b0);
      drain_results();
      write_register(REG_SLOPE, 32'h8000);
      write_register(REG_WIDTH, 32'h7fffffff);
      write_register(REG_HEIGHT, 32'hffff);
      write_register(REG_CENTER, 32'h80000000);
      queue_input(32'h80000000, 1'b0);
      queue_input(32'h7fffffff, 1'b0);
      queue_input(32'h00000000, 1'b0);
      drain_results();
      write_register(REG_SLOPE, 32'h7fff);
      write_register(REG_HEIGHT, 32'd0);
      write_register(REG_CENTER, 32'h7fffffff);
      write_register(REG_WIDTH, 32'd1);
      queue_input(32'h7fffffff, 1'b0);
      queue_input(32'h80000000, 1'b0);
      queue_input(32'h7ffffffe, 1'b0);
      drain_results();
      write_register(REG_HEIGHT, 32'd32768);
      write_register(REG_WIDTH, 32'd65536);
      write_register(REG_CENTER, 32'd0);
      write_register(REG_SLOPE, 32'd256);
      queue_input(32'd65536, 1'b0);
      queue_input(32'd131072, 1'b0);
      drain_results();

      for (int phase = 0; phase < 16; phase++) begin
         random_settings();
         if (phase == 14) quiet_phase = 1'b1;
         for (int i = 0; i < 100; i++) queue_input(random_crisp(), $urandom_range(0, 19) == 0);
         drain_results();
      end

      $display("checked %0d results (%0d invalid) over 21 register settings", checked_count,
               invalid_seen);
      $display("including reset values, field extremes, zero width and both slope signs");
      if (error_count == 0) begin
         $display("tb_bell_membership_function_top passed");
      end else begin
         $display("tb_bell_membership_function_top failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/bmf_pkg.sv
hw/rtl/bmf_if.sv
hw/rtl/bell_membership_function_top.sv
tb/sv/tb_bell_membership_function_top.sv
